### rtl/cartesian_to_polar_top_defines.svh
// ----------------------------------------------------------------------------
// Cartesian to polar assertion macros
// Shared property forms for the checks in the cartesian to polar pipeline.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_POLAR_TOP_DEFINES_SVH
`define CARTESIAN_TO_POLAR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C2P_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define C2P_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/c2p_pkg.sv
// ----------------------------------------------------------------------------
// Cartesian to polar package
// Fixed-point formats, angle constants and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package c2p_pkg;

  localparam int unsigned DEF_ITERATIONS  = 16;
  localparam int unsigned DEF_COORD_WIDTH = 16;

  localparam int unsigned FRAC_BITS    = 24;
  localparam int unsigned ATAN_ENTRIES = 24;

  localparam int unsigned MAG_W   = 16;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned ANGLE_W = 18;

  localparam logic signed [ANGLE_W-1:0] ANGLE_ZERO     = '0;
  localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI  = ANGLE_W'(16384);
  localparam logic signed [ANGLE_W-1:0] ANGLE_NHALF_PI = -ANGLE_W'(16384);
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX      = ANGLE_W'(32767);
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN      = -ANGLE_W'(32768);
  localparam logic [MAG_W-1:0]          MAG_MAX        = '1;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  // Arctangent of 2^-idx in units of pi/32768, rounded to nearest.
  function automatic angle_t atan_unit(input int unsigned idx);
    angle_t val;
    unique case (idx)
      0:       val = ANGLE_W'(8192);
      1:       val = ANGLE_W'(4836);
      2:       val = ANGLE_W'(2555);
      3:       val = ANGLE_W'(1297);
      4:       val = ANGLE_W'(651);
      5:       val = ANGLE_W'(326);
      6:       val = ANGLE_W'(163);
      7:       val = ANGLE_W'(81);
      8:       val = ANGLE_W'(41);
      9:       val = ANGLE_W'(20);
      10:      val = ANGLE_W'(10);
      11:      val = ANGLE_W'(5);
      12:      val = ANGLE_W'(3);
      13:      val = ANGLE_W'(1);
      14:      val = ANGLE_W'(1);
      default: val = ANGLE_ZERO;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### rtl/cartesian_to_polar_top.sv
// A new word can enter on every clock while the output word is not stalled.
// The depth is set by the shared stage chain, where each stage performs one
// CORDIC vectoring step while its index is below ITERATIONS and produces one
// bit of the integer square root while its index is below COORD_WIDTH; the
// front end adds a pre-rotation stage, a squaring stage and a sum stage, and
// a final output register applies saturation and the special cases. When the
// output word is stalled the whole pipeline holds and in_stall is raised.
// ----------------------------------------------------------------------------
// Cartesian to polar top level
// Pipelined magnitude (exact floor square root) and CORDIC angle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cartesian_to_polar_top_defines.svh"

module cartesian_to_polar_top
  import c2p_pkg::*;
#(
  parameter int unsigned ITERATIONS  = DEF_ITERATIONS,
  parameter int unsigned COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [COORD_WIDTH-1:0] in_x_coord,
  input  wire signed [COORD_WIDTH-1:0] in_y_coord,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [MAG_W-1:0]             out_magnitude,
  output logic signed [ANG_W-1:0]      out_angle
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned W  = CW + FRAC_BITS + 3;
  localparam int unsigned NW = 2 * CW;
  localparam int unsigned RW = CW + 2;
  localparam int unsigned N  = (ITERATIONS > CW) ? ITERATIONS : CW;
  localparam int unsigned MW = (CW > MAG_W) ? CW : MAG_W;

  logic adv;

  // Stage 0: absolute values and quadrant pre-rotation.
  logic signed [CW:0]   x_ext, y_ext, x_neg, y_neg;
  logic signed [CW:0]   px, py;
  angle_t               pz;
  logic [CW-1:0]        ax_c, ay_c;

  logic                 v0_r;
  logic [CW-1:0]        ax0_r, ay0_r;
  logic signed [W-1:0]  cx0_r, cy0_r;
  angle_t               z0_r;
  logic                 yz0_r, xn0_r;

  // Stage 1: squares.
  logic [NW-1:0]        sqx_c, sqy_c;
  logic                 v1_r;
  logic [NW-1:0]        sqx1_r, sqy1_r;
  logic signed [W-1:0]  cx1_r, cy1_r;
  angle_t               z1_r;
  logic                 yz1_r, xn1_r;

  // Stage chain, index 0 is the sum stage.
  logic [N:0]           pv_r;
  logic signed [W-1:0]  cx_r [0:N];
  logic signed [W-1:0]  cy_r [0:N];
  angle_t               z_r  [0:N];
  logic [NW-1:0]        nn_r [0:N];
  logic [RW-1:0]        rr_r [0:N];
  logic [CW-1:0]        qq_r [0:N];
  logic [N:0]           yz_r, xn_r;

  // Output register.
  logic                 out_valid_r;
  logic [MAG_W-1:0]     out_magnitude_r;
  logic signed [ANG_W-1:0] out_angle_r;
  logic [MAG_W-1:0]     mag_nxt;
  logic signed [ANG_W-1:0] ang_nxt;
  logic [MW-1:0]        root_ext;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  assign x_ext = {in_x_coord[CW-1], in_x_coord};
  assign y_ext = {in_y_coord[CW-1], in_y_coord};
  assign x_neg = -x_ext;
  assign y_neg = -y_ext;
  assign ax_c  = x_ext[CW] ? x_neg[CW-1:0] : x_ext[CW-1:0];
  assign ay_c  = y_ext[CW] ? y_neg[CW-1:0] : y_ext[CW-1:0];

  always_comb begin
    if (!x_ext[CW]) begin
      px = x_ext;
      py = y_ext;
      pz = ANGLE_ZERO;
    end else if (!y_ext[CW] && (y_ext != '0)) begin
      px = y_ext;
      py = x_neg;
      pz = ANGLE_HALF_PI;
    end else begin
      px = y_neg;
      py = x_ext;
      pz = ANGLE_NHALF_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      pv_r[0] <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      pv_r[0] <= v1_r;
    end
  end

  assign sqx_c = NW'(ax0_r) * NW'(ax0_r);
  assign sqy_c = NW'(ay0_r) * NW'(ay0_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      ax0_r  <= ax_c;
      ay0_r  <= ay_c;
      cx0_r  <= {{(W-CW-1-FRAC_BITS){px[CW]}}, px, {FRAC_BITS{1'b0}}};
      cy0_r  <= {{(W-CW-1-FRAC_BITS){py[CW]}}, py, {FRAC_BITS{1'b0}}};
      z0_r   <= pz;
      yz0_r  <= (in_y_coord == '0);
      xn0_r  <= in_x_coord[CW-1];

      sqx1_r <= sqx_c;
      sqy1_r <= sqy_c;
      cx1_r  <= cx0_r;
      cy1_r  <= cy0_r;
      z1_r   <= z0_r;
      yz1_r  <= yz0_r;
      xn1_r  <= xn0_r;

      nn_r[0] <= sqx1_r + sqy1_r;
      rr_r[0] <= '0;
      qq_r[0] <= '0;
      cx_r[0] <= cx1_r;
      cy_r[0] <= cy1_r;
      z_r[0]  <= z1_r;
      yz_r[0] <= yz1_r;
      xn_r[0] <= xn1_r;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[j+1] <= 1'b0;
      end else if (adv) begin
        pv_r[j+1] <= pv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        yz_r[j+1] <= yz_r[j];
        xn_r[j+1] <= xn_r[j];
      end
    end

    if (j < ITERATIONS) begin : g_rot
      logic signed [W-1:0] dx, dy;
      logic                up;
      assign dx = cy_r[j] >>> j;
      assign dy = cx_r[j] >>> j;
      assign up = (cy_r[j] > 0);
      always_ff @(posedge clk) begin
        if (adv) begin
          if (up) begin
            cx_r[j+1] <= cx_r[j] + dx;
            cy_r[j+1] <= cy_r[j] - dy;
            z_r[j+1]  <= z_r[j] + atan_unit(j);
          end else begin
            cx_r[j+1] <= cx_r[j] - dx;
            cy_r[j+1] <= cy_r[j] + dy;
            z_r[j+1]  <= z_r[j] - atan_unit(j);
          end
        end
      end
    end else begin : g_rot_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          cx_r[j+1] <= cx_r[j];
          cy_r[j+1] <= cy_r[j];
          z_r[j+1]  <= z_r[j];
        end
      end
    end

    if (j < CW) begin : g_root
      logic [RW-1:0] rsh, trial;
      logic          take;
      assign rsh   = {rr_r[j][CW-1:0], nn_r[j][NW-1 -: 2]};
      assign trial = {qq_r[j], 2'b01};
      assign take  = (rsh >= trial);
      always_ff @(posedge clk) begin
        if (adv) begin
          nn_r[j+1] <= {nn_r[j][NW-3:0], 2'b00};
          rr_r[j+1] <= take ? (rsh - trial) : rsh;
          qq_r[j+1] <= {qq_r[j][CW-2:0], take};
        end
      end
    end else begin : g_root_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          nn_r[j+1] <= nn_r[j];
          rr_r[j+1] <= rr_r[j];
          qq_r[j+1] <= qq_r[j];
        end
      end
    end
  end

  assign root_ext = MW'(qq_r[N]);

  always_comb begin
    if (root_ext > MW'(MAG_MAX)) begin
      mag_nxt = MAG_MAX;
    end else begin
      mag_nxt = root_ext[MAG_W-1:0];
    end
    priority if (yz_r[N]) begin
      ang_nxt = xn_r[N] ? ANGLE_MIN[ANG_W-1:0] : ANGLE_ZERO[ANG_W-1:0];
    end else if (z_r[N] > ANGLE_MAX) begin
      ang_nxt = ANGLE_MAX[ANG_W-1:0];
    end else if (z_r[N] < ANGLE_MIN) begin
      ang_nxt = ANGLE_MIN[ANG_W-1:0];
    end else begin
      ang_nxt = z_r[N][ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pv_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_magnitude_r <= mag_nxt;
      out_angle_r     <= ang_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_magnitude_r;
  assign out_angle     = out_angle_r;

  // The root remainder never exceeds twice the root, and the vectoring
  // x value stays non-negative because the pre-rotation lands in the right
  // half plane.
  logic [RW-1:0] root_twice;
  logic          hold_cond;
  logic [N+1:0]  valid_vec;
  assign root_twice = RW'({qq_r[N], 1'b0});
  assign hold_cond  = out_valid_r && out_stall;
  assign valid_vec  = {pv_r, v1_r};

  `C2P_ASSERT_IMP(a_root_rem, clk, rst_n, pv_r[N], rr_r[N] <= root_twice,
    "square root remainder exceeds twice the root")
  `C2P_ASSERT_IMP(a_cordic_x, clk, rst_n, pv_r[N] && !yz_r[N], !cx_r[N][W-1],
    "CORDIC x value went negative")
  `C2P_ASSERT_NXT(a_hold, clk, rst_n, hold_cond, $stable(valid_vec),
    "pipeline valid bits moved while the output word was stalled")

endmodule

`default_nettype wire
